[hdl/segment_endpoint_clustering_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the segment endpoint clustering unit
// Clocked, reset-qualified property checks used by the checker file.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_ENDPOINT_CLUSTERING_UNIT_DEFINES_SVH
`define SEGMENT_ENDPOINT_CLUSTERING_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset
`define SECU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("secu assertion failed");

// Check that a stalled beat keeps its payload
`define SECU_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  `SECU_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> $stable(sig))

`endif

[hdl/secu_pkg.sv]
// ---------------------------------------------------------------------------
// secu_pkg
// Shared types and constants of the segment endpoint clustering unit.
// ---------------------------------------------------------------------------
`default_nettype none

package secu_pkg;

  // Default parameter values
  localparam int unsigned MAX_CLUSTERS_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 16;

  // Fixed field widths
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned IDXOUT_W = 8;

  localparam logic [CNT_W-1:0]   MEMBER_CAP  = 10'd512;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd256;

  typedef logic [LIMIT_W-1:0] limit_t;

  // One segment beat
  typedef struct packed {
    logic [FIELD_W-1:0] end_a_x;
    logic [FIELD_W-1:0] end_a_y;
    logic [FIELD_W-1:0] end_b_x;
    logic [FIELD_W-1:0] end_b_y;
    logic               removed;
  } seg_t;

  // One result beat
  typedef struct packed {
    logic [IDXOUT_W-1:0] cluster_index;
    logic                opened_new;
    logic [CNT_W-1:0]    member_total;
    logic                table_full;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

[hdl/secu_stream_if.sv]
// ---------------------------------------------------------------------------
// secu_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ---------------------------------------------------------------------------
`default_nettype none

interface secu_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/secu_ram.sv]
// ---------------------------------------------------------------------------
// secu_ram
// Cluster table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module secu_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 42
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write a beat into the table
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/secu_dist.sv]
// ---------------------------------------------------------------------------
// secu_dist
// Squared distance of a point to a representative, compared to the limit.
// ---------------------------------------------------------------------------
`default_nettype none

module secu_dist #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [COORD_BITS-1:0] pt_x_i,
  input  logic [COORD_BITS-1:0] pt_y_i,
  input  logic [COORD_BITS-1:0] rep_x_i,
  input  logic [COORD_BITS-1:0] rep_y_i,
  input  secu_pkg::limit_t      limit_i,
  output logic                  hit_o
);
  import secu_pkg::*;

  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam int unsigned CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       sq_x_q, sq_y_q;
  logic [SUM_W-1:0]      sum;

  // Absolute differences
  assign dx = (pt_x_i > rep_x_i) ? (pt_x_i - rep_x_i) : (rep_x_i - pt_x_i);
  assign dy = (pt_y_i > rep_y_i) ? (pt_y_i - rep_y_i) : (rep_y_i - pt_y_i);

  // Square and register the products
  always_ff @(posedge clk_i) begin
    sq_x_q <= SQ_W'(dx) * SQ_W'(dx);
    sq_y_q <= SQ_W'(dy) * SQ_W'(dy);
  end

  // Full-width sum never wraps, so no saturation is needed
  assign sum   = SUM_W'(sq_x_q) + SUM_W'(sq_y_q);
  assign hit_o = CMP_W'(sum) < CMP_W'(limit_i);

endmodule

`default_nettype wire

[hdl/segment_endpoint_clustering_unit.sv]
// Order: a kept segment gives its first result after scanning the clusters newest
//   first, and its second after a second newest-first scan.
// Throughput: one cluster per cycle through the table's single read port during a
//   scan; the next segment waits for the second result; removed ones skip the scan.
// Reset: clears control state and the cluster count and loads the limit with 256;
//   the table itself is not cleared, only entries below the count are ever read.
// ---------------------------------------------------------------------------
// segment_endpoint_clustering_unit
// Greedy leader clustering of segment endpoints over a cluster table memory.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_endpoint_clustering_unit #(
  parameter int unsigned MAX_CLUSTERS = secu_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned COORD_BITS   = secu_pkg::COORD_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  secu_stream_if.sink   cfg_i,
  secu_stream_if.sink   in_i,
  secu_stream_if.source out_o
);
  import secu_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CLUSTERS);
  localparam int unsigned TOT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned ENT_W = 2 * COORD_BITS + CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic                  first_q, first_d;
  logic                  seg_first_q, seg_first_d;
  logic                  last_q, last_d;
  logic [COORD_BITS-1:0] pt_x_q, pt_x_d, pt_y_q, pt_y_d;
  logic [COORD_BITS-1:0] b_x_q, b_x_d, b_y_q, b_y_d;
  logic [TOT_W-1:0]      total_q, total_d;
  limit_t                limit_q, limit_d;
  logic [IDX_W-1:0]      issue_k_q, issue_k_d;
  logic                  issue_left_q, issue_left_d;
  logic                  v1_q, v1_d, v2_q, v2_d;
  logic [IDX_W-1:0]      idx1_q, idx1_d, idx2_q, idx2_d;
  logic [CNT_W-1:0]      cnt2_q, cnt2_d;
  res_t                  res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_data_q, out_data_d;

  logic                  rd_en;
  logic [ENT_W-1:0]      rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic [COORD_BITS-1:0] rep_x, rep_y;
  logic [CNT_W-1:0]      rep_cnt, cnt_inc;
  logic                  dist_hit, hit, miss, out_free;
  logic [TOT_W-1:0]      total_m1;

  // Unpack the table word
  assign rep_x   = rd_data[ENT_W-1 -: COORD_BITS];
  assign rep_y   = rd_data[CNT_W +: COORD_BITS];
  assign rep_cnt = rd_data[CNT_W-1:0];

  assign cnt_inc  = (cnt2_q < MEMBER_CAP) ? (cnt2_q + CNT_W'(1)) : cnt2_q;
  assign hit      = (state_q == ST_SCAN) && v2_q && dist_hit;
  assign miss     = (state_q == ST_SCAN) && !issue_left_q && !v1_q && !v2_q;
  assign rd_en    = (state_q == ST_SCAN) && issue_left_q && !hit;
  assign out_free = !out_valid_q || out_o.ready;
  assign total_m1 = total_q - TOT_W'(1);

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  secu_ram #(
    .DEPTH(MAX_CLUSTERS),
    .WIDTH(ENT_W)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(issue_k_q),
    .rd_data_o(rd_data)
  );

  secu_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .pt_x_i (pt_x_q),
    .pt_y_i (pt_y_q),
    .rep_x_i(rep_x),
    .rep_y_i(rep_y),
    .limit_i(limit_q),
    .hit_o  (dist_hit)
  );

  // Sequence the scan, write back and result handoff
  always_comb begin
    state_d      = state_q;
    first_d      = first_q;
    seg_first_d  = seg_first_q;
    last_d       = last_q;
    pt_x_d       = pt_x_q;
    pt_y_d       = pt_y_q;
    b_x_d        = b_x_q;
    b_y_d        = b_y_q;
    total_d      = total_q;
    limit_d      = limit_q;
    issue_k_d    = issue_k_q;
    issue_left_d = issue_left_q;
    v1_d         = rd_en;
    idx1_d       = issue_k_q;
    v2_d         = v1_q;
    idx2_d       = idx1_q;
    cnt2_d       = rep_cnt;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;
    wr_en        = 1'b0;
    wr_addr      = idx2_q;
    wr_data      = {pt_x_q, pt_y_q, cnt_inc};

    // Take a new limit
    if (cfg_i.valid) begin
      limit_d = cfg_i.data;
    end

    // Step the read address down
    if (rd_en) begin
      if (issue_k_q == '0) begin
        issue_left_d = 1'b0;
      end else begin
        issue_k_d = issue_k_q - IDX_W'(1);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && !in_i.data.removed) begin
          pt_x_d       = COORD_BITS'(in_i.data.end_a_x);
          pt_y_d       = COORD_BITS'(in_i.data.end_a_y);
          b_x_d        = COORD_BITS'(in_i.data.end_b_x);
          b_y_d        = COORD_BITS'(in_i.data.end_b_y);
          last_d       = 1'b0;
          seg_first_d  = !first_q;
          first_d      = 1'b1;
          issue_k_d    = total_m1[IDX_W-1:0];
          issue_left_d = first_q && (total_q != '0);
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // Join the newest matching cluster
          wr_en        = 1'b1;
          res_d        = '{cluster_index: IDXOUT_W'(idx2_q), opened_new: 1'b0,
                           member_total: cnt_inc, table_full: 1'b0, last: last_q};
          v1_d         = 1'b0;
          v2_d         = 1'b0;
          issue_left_d = 1'b0;
          state_d      = ST_EMIT;
        end else if (miss) begin
          // Open a cluster, or flag a full table
          if (total_q < TOT_W'(MAX_CLUSTERS)) begin
            wr_en   = 1'b1;
            wr_addr = total_q[IDX_W-1:0];
            wr_data = {pt_x_q, pt_y_q, CNT_W'(1)};
            res_d   = '{cluster_index: IDXOUT_W'(total_q[IDX_W-1:0]), opened_new: 1'b1,
                        member_total: CNT_W'(1), table_full: 1'b0, last: last_q};
            total_d = total_q + TOT_W'(1);
          end else begin
            res_d   = '{cluster_index: '0, opened_new: 1'b0,
                        member_total: '0, table_full: 1'b1, last: last_q};
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          if (!last_q) begin
            // Move on to the second endpoint
            last_d       = 1'b1;
            pt_x_d       = b_x_q;
            pt_y_d       = b_y_q;
            issue_k_d    = total_m1[IDX_W-1:0];
            issue_left_d = !seg_first_q && (total_q != '0);
            state_d      = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_q      <= 1'b0;
      seg_first_q  <= 1'b0;
      last_q       <= 1'b0;
      pt_x_q       <= '0;
      pt_y_q       <= '0;
      b_x_q        <= '0;
      b_y_q        <= '0;
      total_q      <= '0;
      limit_q      <= LIMIT_RESET;
      issue_k_q    <= '0;
      issue_left_q <= 1'b0;
      v1_q         <= 1'b0;
      idx1_q       <= '0;
      v2_q         <= 1'b0;
      idx2_q       <= '0;
      cnt2_q       <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      first_q      <= first_d;
      seg_first_q  <= seg_first_d;
      last_q       <= last_d;
      pt_x_q       <= pt_x_d;
      pt_y_q       <= pt_y_d;
      b_x_q        <= b_x_d;
      b_y_q        <= b_y_d;
      total_q      <= total_d;
      limit_q      <= limit_d;
      issue_k_q    <= issue_k_d;
      issue_left_q <= issue_left_d;
      v1_q         <= v1_d;
      idx1_q       <= idx1_d;
      v2_q         <= v2_d;
      idx2_q       <= idx2_d;
      cnt2_q       <= cnt2_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

endmodule

`default_nettype wire

[hdl/secu_checker.sv]
// ---------------------------------------------------------------------------
// secu_checker
// Port-level checks of the clustering unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segment_endpoint_clustering_unit_defines.svh"

module secu_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input secu_pkg::res_t  out_data_i
);
  import secu_pkg::*;

  // Hold a stalled result beat
  `SECU_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `SECU_ASSERT_HOLD(a_out_data_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_data_i)

  // A first-endpoint result pending means the segment is still in work
  `SECU_ASSERT(a_no_accept_mid_segment, clk_i, rst_ni,
               out_valid_i && !out_data_i.last |-> !in_ready_i)

  // A full table opens nothing and counts no member
  `SECU_ASSERT(a_full_result, clk_i, rst_ni,
               out_valid_i && out_data_i.table_full |->
               !out_data_i.opened_new && (out_data_i.member_total == '0))

endmodule

bind segment_endpoint_clustering_unit secu_checker u_secu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

`default_nettype wire

[bench/tb_segment_endpoint_clustering_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_segment_endpoint_clustering_unit
// Self-checking bench for the endpoint clustering unit. It feeds segment beats
// with random idling and stalls, keeps its own copy of the cluster table to
// predict the per-endpoint result beats, and compares each result beat in order.
// It sweeps the join limit across several values, zero and all-ones among them.
// ---------------------------------------------------------------------------
module tb_segment_endpoint_clustering_unit;
  import secu_pkg::*;

  localparam int unsigned NUM_CLUSTERS  = MAX_CLUSTERS_DEF;
  // Worst-case scan of both endpoints plus margin
  localparam int          SETTLE_CYCLES = 2 * NUM_CLUSTERS + 40;
  localparam int          HOLD_CYCLES   = 700;
  // Whole-run watchdog bound, sized for full scans, long sender gaps and receiver stalls
  localparam longint      CYCLE_LIMIT   = 4_000_000;
  localparam int          NUM_PHASES    = 6;

  logic clk_i;
  logic rst_ni;

  secu_stream_if #(.T(limit_t)) cfg_if ();
  secu_stream_if #(.T(seg_t))   seg_if ();
  secu_stream_if #(.T(res_t))   res_if ();

  segment_endpoint_clustering_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (seg_if),
    .out_o (res_if)
  );

  // -------------------------------------------------------------------------
  // Cluster table shadow and expected result beats
  // -------------------------------------------------------------------------
  class cluster_board;
    limit_t      join_limit;
    logic [15:0] rep_x [NUM_CLUSTERS];
    logic [15:0] rep_y [NUM_CLUSTERS];
    int unsigned members [NUM_CLUSTERS];
    int unsigned opened;
    bit          seen_first;
    res_t        expected [$];
    int unsigned errors;

    function new();
      join_limit = LIMIT_RESET;
      opened     = 0;
      seen_first = 1'b0;
      errors     = 0;
    endfunction

    function void set_limit(limit_t v);
      join_limit = v;
    endfunction

    // Open a cluster at the point, or flag a full table and drop the point
    function res_t open_cluster(logic [15:0] x, logic [15:0] y, logic is_b);
      res_t r;
      r      = '0;
      r.last = is_b;
      if (opened >= NUM_CLUSTERS) begin
        r.table_full = 1'b1;
      end else begin
        rep_x[opened]   = x;
        rep_y[opened]   = y;
        members[opened] = 1;
        r.cluster_index = IDXOUT_W'(opened);
        r.opened_new    = 1'b1;
        r.member_total  = CNT_W'(1);
        opened++;
      end
      return r;
    endfunction

    // Scan newest first; the first close representative takes the point
    function res_t place_endpoint(logic [15:0] x, logic [15:0] y, logic is_b);
      res_t            r;
      longint unsigned dx, dy;
      for (int k = int'(opened) - 1; k >= 0; k--) begin
        dx = (rep_x[k] > x) ? rep_x[k] - x : x - rep_x[k];
        dy = (rep_y[k] > y) ? rep_y[k] - y : y - rep_y[k];
        // 16-bit coordinates cannot overflow the 64-bit sum
        if (dx * dx + dy * dy < {32'd0, join_limit}) begin
          rep_x[k] = x;
          rep_y[k] = y;
          if (members[k] < MEMBER_CAP) members[k]++;
          r               = '0;
          r.cluster_index = IDXOUT_W'(k);
          r.member_total  = CNT_W'(members[k]);
          r.last          = is_b;
          return r;
        end
      end
      return open_cluster(x, y, is_b);
    endfunction

    function void note_segment(seg_t s);
      if (s.removed) return;
      if (!seen_first) begin
        // First kept segment opens two clusters no matter how close
        seen_first = 1'b1;
        expected.push_back(open_cluster(s.end_a_x, s.end_a_y, 1'b0));
        expected.push_back(open_cluster(s.end_b_x, s.end_b_y, 1'b1));
      end else begin
        expected.push_back(place_endpoint(s.end_a_x, s.end_a_y, 1'b0));
        expected.push_back(place_endpoint(s.end_b_x, s.end_b_y, 1'b1));
      end
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
        return;
      end
      want = expected.pop_front();
      if (got.cluster_index !== want.cluster_index)
        report($sformatf("cluster_index %0d, want %0d", got.cluster_index, want.cluster_index));
      if (got.opened_new !== want.opened_new)
        report($sformatf("opened_new %b, want %b", got.opened_new, want.opened_new));
      if (got.member_total !== want.member_total)
        report($sformatf("member_total %0d, want %0d", got.member_total, want.member_total));
      if (got.table_full !== want.table_full)
        report($sformatf("table_full %b, want %b", got.table_full, want.table_full));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  cluster_board    board;
  int unsigned     snd_idle_pct = 22;
  int unsigned     rcv_idle_pct = 73;
  bit              hold_request = 1'b0;
  longint unsigned cycles;
  logic [15:0]     recent_x [$];
  logic [15:0]     recent_y [$];

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_segment_endpoint_clustering_unit: errors");
    $finish;
  end

  // Check result beats and drive ready, with an occasional long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) board.check_result(res_if.data);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic seg_t make_seg(logic [15:0] ax, logic [15:0] ay,
                                    logic [15:0] bx, logic [15:0] by, logic rm);
    seg_t s;
    s.end_a_x = ax;
    s.end_a_y = ay;
    s.end_b_x = bx;
    s.end_b_y = by;
    s.removed = rm;
    return s;
  endfunction

  // Nudge a coordinate by a small, medium or wide offset, clamped to range
  function automatic logic [15:0] jitter(logic [15:0] c);
    int span;
    int v;
    case ($urandom_range(2))
      0:       span = 4;
      1:       span = 24;
      default: span = 400;
    endcase
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Mostly revisit recent points so that joins happen; else corners or anywhere
  function automatic void pick_point(output logic [15:0] x, output logic [15:0] y);
    int unsigned r;
    int unsigned i;
    r = $urandom_range(99);
    if (r < 60 && recent_x.size() > 0) begin
      i = $urandom_range(recent_x.size() - 1);
      x = jitter(recent_x[i]);
      y = jitter(recent_y[i]);
    end else if (r < 72) begin
      x = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end else begin
      x = 16'($urandom());
      y = 16'($urandom());
    end
  endfunction

  // Offer one segment beat after random idle cycles; note it once taken
  task automatic send_seg(input seg_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_if.valid <= 1'b1;
    seg_if.data  <= s;
    do @(posedge clk_i); while (!seg_if.ready);
    board.note_segment(s);
  endtask

  task automatic write_limit(input limit_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.set_limit(v);
  endtask

  // Hold until every expected beat is out and a removed beat has drained too
  task automatic wait_idle();
    while (board.expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    seg_t   directed [$];
    seg_t   s;
    limit_t lim;
    int     kept_goal;
    int     kept;

    board = new();
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    seg_if.valid <= 1'b0;
    seg_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset limit of 256 on the squared distance
    directed.push_back(make_seg(16'($urandom()), 16'($urandom()),
                                16'($urandom()), 16'($urandom()), 1'b1));
    directed.push_back(make_seg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // first kept segment: both open, even on the same point
    directed.push_back(make_seg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    // a joins exactly, b joins just inside the limit
    directed.push_back(make_seg(16'h0000, 16'h0000, 16'h000F, 16'h0000, 1'b0));
    // a sits exactly on the limit and opens; b joins the cluster a opened
    directed.push_back(make_seg(16'h001F, 16'h0000, 16'h001F, 16'h000F, 1'b0));
    directed.push_back(make_seg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0));
    directed.push_back(make_seg(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    directed.push_back(make_seg(16'h0010, 16'h0000, 16'h0000, 16'h0010, 1'b1));
    directed.push_back(make_seg(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    directed.push_back(make_seg(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0));
    directed.push_back(make_seg(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0));
    directed.push_back(make_seg(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0));
    foreach (directed[i]) send_seg(directed[i]);
    seg_if.valid <= 1'b0;

    // Random phases: moderate limit, zero (fills the table), random,
    // all-ones (saturates member counts), reset value, small
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       begin lim = 32'($urandom_range(32'h0001_0000, 32'h0000_0100)); kept_goal = 175; end
        1:       begin lim = 32'h0000_0000;                                      kept_goal = 135; end
        2:       begin lim = 32'($urandom());                                    kept_goal = 175; end
        3:       begin lim = 32'hFFFF_FFFF;                                      kept_goal = 300; end
        4:       begin lim = LIMIT_RESET;                                        kept_goal = 130; end
        default: begin lim = 32'($urandom_range(4096));                          kept_goal = 155; end
      endcase
      if (p < 2) begin
        snd_idle_pct = 22;
        rcv_idle_pct = 73;
      end else if (p < 4) begin
        snd_idle_pct = 73;
        rcv_idle_pct = 22;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_limit(lim);
      // Stall the result side while segments keep coming
      if (p == 0 || p == 4) hold_request = 1'b1;

      kept = 0;
      while (kept < kept_goal) begin
        pick_point(s.end_a_x, s.end_a_y);
        if ($urandom_range(99) < 40) begin
          s.end_b_x = jitter(s.end_a_x);
          s.end_b_y = jitter(s.end_a_y);
        end else begin
          pick_point(s.end_b_x, s.end_b_y);
        end
        s.removed = ($urandom_range(99) < 8);
        if (!s.removed) begin
          kept++;
          recent_x.push_back(s.end_b_x);
          recent_y.push_back(s.end_b_y);
          if (recent_x.size() > 16) begin
            void'(recent_x.pop_front());
            void'(recent_y.pop_front());
          end
        end
        send_seg(s);
      end
      seg_if.valid <= 1'b0;
    end

    wait_idle();
    if (board.errors == 0) begin
      $display("tb_segment_endpoint_clustering_unit: clean");
    end else begin
      $display("tb_segment_endpoint_clustering_unit: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/secu_pkg.sv
hdl/secu_stream_if.sv
hdl/secu_ram.sv
hdl/secu_dist.sv
hdl/segment_endpoint_clustering_unit.sv
hdl/secu_checker.sv
bench/tb_segment_endpoint_clustering_unit.sv
